// File: hw/rtl/cfe_pkg.sv
package cfe_pkg;

    localparam int EPOCH_YEAR         = 1970;
    localparam int WINDOW_PIVOT       = 68;
    localparam int CENTURY_BASE       = 1900;
    localparam int HOURS_PER_DAY      = 24;
    localparam int MIN_PER_HOUR       = 60;
    localparam int SEC_PER_HOUR       = 3600;
    localparam int SEC_PER_DAY        = 86400;
    localparam int DAYS_PER_YEAR      = 365;
    // leap years in 1..1969
    localparam int LEAPS_BEFORE_EPOCH = 477;
    // floor(y / 100) = (y * RECIP100) >> RECIP_SHIFT, exact for y < 2^15
    localparam int RECIP100           = 5243;
    localparam int RECIP_SHIFT        = 19;

    localparam logic signed [17:0] ZONE_LIMIT = 18'sd86400;
    localparam logic [38:0]        RESULT_MAX = 39'd253402387199;

    // register indexes of the configuration port
    localparam logic CFG_UTC_MODE = 1'b0;
    localparam logic CFG_ZONE     = 1'b1;

    typedef enum logic [1:0] {
        FORM_HHMM = 2'd0,
        FORM_MMDD = 2'd1,
        FORM_YY   = 2'd2,
        FORM_CCYY = 2'd3
    } form_t;

    typedef struct packed {
        form_t       form;
        logic [6:0]  month_field;
        logic [6:0]  day_field;
        logic [6:0]  hour_field;
        logic [6:0]  minute_field;
        logic [13:0] year_field;
        logic [5:0]  second_field;
        logic [13:0] current_year;
        logic [3:0]  current_month;
        logic [4:0]  current_day;
    } item_t;

    typedef struct packed {
        logic        utc_mode;
        logic [17:0] zone;
    } cfg_t;

    // front half to back half
    typedef struct packed {
        logic [14:0] year;
        logic        leap;
        logic [12:0] leaps;
        logic [8:0]  doy;
        logic [16:0] tod;
        logic        ok;
    } fb_t;

    function automatic logic [4:0] days_in_month(input logic [3:0] mm);
        logic [4:0] d;
        case (mm)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
            4'd2:                                         d = 5'd28;
            default:                                      d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] mm);
        logic [8:0] d;
        case (mm)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/calendar_fields_to_epoch_seconds.sv
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: date fields, s_tuser: form code
// m        out  m_tvalid/m_tready  m_tdata: epoch seconds, m_tuser: bad_date
// cfg      in   cfg_we             cfg_index, cfg_data
//
// One beat per cycle sustained while m accepts; five register stages from accept to m_tvalid.
// Year / 100 by reciprocal multiply, days * 86400 on its own stage.
// Reset clears the stage valid bits and the config registers (local mode,
// zero offset). A stall on m holds every stage that is full; s_tready drops
// only when the whole pipe is full and m is stalled.
module calendar_fields_to_epoch_seconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] month_field, [13:7] day_field, [20:14] hour_field, [27:21] minute_field,
    // [41:28] year_field, [47:42] second_field, [61:48] current_year,
    // [65:62] current_month, [70:66] current_day, [71] zero
    input  logic [71:0] s_tdata,
    // [1:0] form
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [38:0] epoch_seconds, [39] zero
    output logic [39:0] m_tdata,
    // [0] bad_date
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [17:0] cfg_data
);

    logic         utc_mode_reg;
    logic [17:0]  zone_reg, zone_next;
    logic signed [17:0] zone_in;

    cfe_pkg::item_t item;
    cfe_pkg::cfg_t  cfg;
    cfe_pkg::fb_t   fb_data;
    logic           fb_valid;
    logic           fb_ready;
    logic [38:0]    epoch;

    always_comb
    begin
        zone_in = signed'(cfg_data);
        if (zone_in > cfe_pkg::ZONE_LIMIT)
            zone_next = cfe_pkg::ZONE_LIMIT;
        else if (zone_in < -cfe_pkg::ZONE_LIMIT)
            zone_next = -cfe_pkg::ZONE_LIMIT;
        else
            zone_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_mode_reg <= 1'b0;
            zone_reg     <= 18'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfe_pkg::CFG_UTC_MODE: utc_mode_reg <= cfg_data[0];
                cfe_pkg::CFG_ZONE:     zone_reg     <= zone_next;
                default:               ;
            endcase
        end
    end

    assign cfg.utc_mode = utc_mode_reg;
    assign cfg.zone     = zone_reg;

    assign item.form          = cfe_pkg::form_t'(s_tuser);
    assign item.month_field   = s_tdata[6:0];
    assign item.day_field     = s_tdata[13:7];
    assign item.hour_field    = s_tdata[20:14];
    assign item.minute_field  = s_tdata[27:21];
    assign item.year_field    = s_tdata[41:28];
    assign item.second_field  = s_tdata[47:42];
    assign item.current_year  = s_tdata[61:48];
    assign item.current_month = s_tdata[65:62];
    assign item.current_day   = s_tdata[70:66];

    cfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (item),
        .out_valid (fb_valid),
        .out_ready (fb_ready),
        .out_data  (fb_data)
    );

    cfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fb_valid),
        .in_ready  (fb_ready),
        .in_data   (fb_data),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .epoch     (epoch),
        .bad       (m_tuser)
    );

    assign m_tdata = {1'b0, epoch};

endmodule

// File: hw/rtl/cfe_front.sv
module cfe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cfe_pkg::item_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cfe_pkg::fb_t   out_data
);

    // stage A: field selection, range checks, year / 100
    logic        vld_a_reg;
    logic        rdy_a;
    logic [14:0] yy_a_reg, yy_a_next;
    logic [3:0]  mm_a_reg, mm_a_next;
    logic [7:0]  dd_a_reg, dd_a_next;
    logic [4:0]  hh_a_reg, hh_a_next;
    logic [5:0]  mi_a_reg, mi_a_next;
    logic [5:0]  ss_a_reg, ss_a_next;
    logic [8:0]  q100_a_reg, q100_a_next;
    logic        ok_a_reg, ok_a_next;

    // stage B: leap test, day of year, time of day
    logic         vld_b_reg;
    logic         rdy_b;
    cfe_pkg::fb_t fb_b_reg, fb_b_next;

    logic [6:0]  mm7;
    logic [6:0]  dd7;
    logic [6:0]  hh_eff;
    logic [27:0] recip_prod;
    logic [15:0] hund;
    logic        rem_zero;
    logic        leap;
    logic [4:0]  limit;

    assign rdy_b    = !vld_b_reg || out_ready;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        case (in_data.form)
            cfe_pkg::FORM_CCYY:
                yy_a_next = {1'b0, in_data.year_field};
            cfe_pkg::FORM_YY:
                if ({1'b0, in_data.year_field} <= 15'(cfe_pkg::WINDOW_PIVOT))
                    yy_a_next = 15'(cfe_pkg::CENTURY_BASE + 100) + {1'b0, in_data.year_field};
                else
                    yy_a_next = 15'(cfe_pkg::CENTURY_BASE) + {1'b0, in_data.year_field};
            default:
                yy_a_next = {1'b0, in_data.current_year};
        endcase

        if (in_data.form == cfe_pkg::FORM_HHMM)
        begin
            mm7 = {3'b000, in_data.current_month};
            dd7 = {2'b00, in_data.current_day};
        end
        else
        begin
            mm7 = in_data.month_field;
            dd7 = in_data.day_field;
        end

        // hour 24 rolls into the next day
        if (in_data.hour_field == 7'(cfe_pkg::HOURS_PER_DAY))
        begin
            hh_eff    = 7'd0;
            dd_a_next = {1'b0, dd7} + 8'd1;
        end
        else
        begin
            hh_eff    = in_data.hour_field;
            dd_a_next = {1'b0, dd7};
        end

        ok_a_next = (mm7 >= 7'd1) && (mm7 <= 7'd12) && (dd_a_next != 8'd0) &&
                    (hh_eff <= 7'(cfe_pkg::HOURS_PER_DAY - 1)) &&
                    (in_data.minute_field <= 7'(cfe_pkg::MIN_PER_HOUR - 1)) &&
                    (in_data.second_field <= 6'(cfe_pkg::MIN_PER_HOUR - 1));

        mm_a_next = mm7[3:0];
        hh_a_next = hh_eff[4:0];
        mi_a_next = in_data.minute_field[5:0];
        ss_a_next = in_data.second_field;

        recip_prod  = 28'(yy_a_next) * 28'(cfe_pkg::RECIP100);
        q100_a_next = recip_prod[27:cfe_pkg::RECIP_SHIFT];
    end

    always_comb
    begin
        hund     = 16'(q100_a_reg) * 16'd100;
        rem_zero = (hund == {1'b0, yy_a_reg});
        leap     = (yy_a_reg[1:0] == 2'b00) && (!rem_zero || (q100_a_reg[1:0] == 2'b00));
        limit    = cfe_pkg::days_in_month(mm_a_reg) + 5'((mm_a_reg == 4'd2) && leap);

        fb_b_next.year  = yy_a_reg;
        fb_b_next.leap  = leap;
        fb_b_next.leaps = 13'(yy_a_reg >> 2) - 13'(q100_a_reg) + 13'(q100_a_reg >> 2);
        fb_b_next.doy   = cfe_pkg::days_before_month(mm_a_reg) +
                          9'(leap && (mm_a_reg >= 4'd3)) + 9'(dd_a_reg) - 9'd1;
        fb_b_next.tod   = 17'(hh_a_reg) * 17'(cfe_pkg::SEC_PER_HOUR) +
                          17'(mi_a_reg) * 17'(cfe_pkg::MIN_PER_HOUR) + 17'(ss_a_reg);
        fb_b_next.ok    = ok_a_reg && (dd_a_reg <= {3'b000, limit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                vld_a_reg <= in_valid;
            if (rdy_b)
                vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            yy_a_reg   <= yy_a_next;
            mm_a_reg   <= mm_a_next;
            dd_a_reg   <= dd_a_next;
            hh_a_reg   <= hh_a_next;
            mi_a_reg   <= mi_a_next;
            ss_a_reg   <= ss_a_next;
            q100_a_reg <= q100_a_next;
            ok_a_reg   <= ok_a_next;
        end
        if (rdy_b && vld_a_reg)
            fb_b_reg <= fb_b_next;
    end

    assign out_valid = vld_b_reg;
    assign out_data  = fb_b_reg;

endmodule

// File: hw/rtl/cfe_back.sv
module cfe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cfe_pkg::fb_t   in_data,
    input  cfe_pkg::cfg_t  cfg,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [38:0]    epoch,
    output logic           bad
);

    // stage C: whole days since epoch
    logic        vld_c_reg;
    logic        rdy_c;
    logic [22:0] days_c_reg, days_c_next;
    logic [16:0] tod_c_reg;
    logic        ok_c_reg;

    // stage D: days to seconds
    logic        vld_d_reg;
    logic        rdy_d;
    logic [39:0] prod_d_reg, prod_d_next;
    logic [16:0] tod_d_reg;
    logic        ok_d_reg;

    // stage E: add time of day and zone, clamp
    logic        vld_e_reg;
    logic        rdy_e;
    logic [38:0] epoch_e_reg, epoch_e_next;
    logic        bad_e_reg, bad_e_next;

    logic [14:0] yrs;
    logic [22:0] year_days;
    logic [41:0] zone_ext;
    logic [41:0] sum;

    assign rdy_e    = !vld_e_reg || out_ready;
    assign rdy_d    = !vld_d_reg || rdy_e;
    assign rdy_c    = !vld_c_reg || rdy_d;
    assign in_ready = rdy_c;

    always_comb
    begin
        yrs = in_data.year - 15'(cfe_pkg::EPOCH_YEAR);
        if (in_data.year > 15'(cfe_pkg::EPOCH_YEAR))
            year_days = 23'(yrs) * 23'(cfe_pkg::DAYS_PER_YEAR) + 23'(in_data.leaps) -
                        23'(in_data.leap) - 23'(cfe_pkg::LEAPS_BEFORE_EPOCH);
        else
            year_days = 23'd0;
        days_c_next = year_days + 23'(in_data.doy);
    end

    assign prod_d_next = 40'(days_c_reg) * 40'(cfe_pkg::SEC_PER_DAY);

    always_comb
    begin
        if (cfg.utc_mode)
            zone_ext = 42'd0;
        else
            zone_ext = {{24{cfg.zone[17]}}, cfg.zone};
        sum = {2'b00, prod_d_reg} + {25'd0, tod_d_reg} + zone_ext;

        if (!ok_d_reg)
        begin
            epoch_e_next = 39'd0;
            bad_e_next   = 1'b1;
        end
        else if (!sum[41] && (sum[40:0] > {2'b00, cfe_pkg::RESULT_MAX}))
        begin
            epoch_e_next = cfe_pkg::RESULT_MAX;
            bad_e_next   = 1'b0;
        end
        else
        begin
            epoch_e_next = sum[38:0];
            bad_e_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else
        begin
            if (rdy_c)
                vld_c_reg <= in_valid;
            if (rdy_d)
                vld_d_reg <= vld_c_reg;
            if (rdy_e)
                vld_e_reg <= vld_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && in_valid)
        begin
            days_c_reg <= days_c_next;
            tod_c_reg  <= in_data.tod;
            ok_c_reg   <= in_data.ok;
        end
        if (rdy_d && vld_c_reg)
        begin
            prod_d_reg <= prod_d_next;
            tod_d_reg  <= tod_c_reg;
            ok_d_reg   <= ok_c_reg;
        end
        if (rdy_e && vld_d_reg)
        begin
            epoch_e_reg <= epoch_e_next;
            bad_e_reg   <= bad_e_next;
        end
    end

    assign out_valid = vld_e_reg;
    assign epoch     = epoch_e_reg;
    assign bad       = bad_e_reg;

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_e_reg && bad_e_reg |-> epoch_e_reg == 39'd0)
        else $error("rejected date with nonzero seconds");

    a_negative_needs_zone: assert property (@(posedge clk) disable iff (!rst_n)
        vld_e_reg && !bad_e_reg && epoch_e_reg[38] |-> !cfg.utc_mode && cfg.zone[17])
        else $error("negative result without a negative zone offset");

    a_stage_d_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_d_reg && !rdy_d |=> vld_d_reg && $stable(prod_d_reg) && $stable(ok_d_reg))
        else $error("stage D lost or changed a stalled item");

    a_accept_fills_c: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_c_reg)
        else $error("accepted item did not reach stage C");

endmodule
